// ===== rtl/core/eqpc_pkg.sv =====
// Package with shared types and codes for the paint-coalescing message queue.
`timescale 1ns / 1ps
package eqpc_pkg;

  localparam int KindW = 16;
  localparam int CoordW = 16;
  localparam int PayW = 32;
  localparam int EntryW = KindW + 4 * CoordW + PayW;
  localparam logic [KindW-1:0] PaintKindReset = 16'd15;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_PREPEND = 2'd1,
    OP_TAKE    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELIVER  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_WAITING  = 3'd4
  } status_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic signed [CoordW-1:0] l;
    logic signed [CoordW-1:0] t;
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] b;
    logic [PayW-1:0] pay;
  } entry_t;

  typedef struct packed {
    op_t op;
    logic wait_req;
    entry_t ent;
  } req_t;

  typedef struct packed {
    status_t status;
    entry_t ent;
    logic last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_TAKE_RD,
    S_SCAN_RD,
    S_SCAN_WR,
    S_OUT,
    S_DELIVER
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_req;
    logic do_insert;
    logic take_rd;
    logic take_load;
    logic scan_rd;
    logic scan_step;
    logic set_out;
    status_t out_status;
    logic out_ent;
    logic out_last;
    logic post_take;
    logic set_pending;
    logic clr_pending;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t op;
    logic wait_req;
    logic full;
    logic empty;
    logic pending;
    logic coalesce;
    logic scan_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/core/eqpc_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface eqpc_req_if;
  import eqpc_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic wait_req;
  logic [15:0] msg_kind;
  logic signed [15:0] rect_left;
  logic signed [15:0] rect_top;
  logic signed [15:0] rect_right;
  logic signed [15:0] rect_bottom;
  logic [31:0] payload;
  modport source (output valid, op, wait_req, msg_kind, rect_left, rect_top, rect_right,
                  rect_bottom, payload, input ready);
  modport sink (input valid, op, wait_req, msg_kind, rect_left, rect_top, rect_right,
                rect_bottom, payload, output ready);
endinterface

interface eqpc_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [15:0] out_kind;
  logic signed [15:0] out_left;
  logic signed [15:0] out_top;
  logic signed [15:0] out_right;
  logic signed [15:0] out_bottom;
  logic [31:0] out_payload;
  logic [4:0] queue_count;
  logic queue_nonempty;
  logic last;
  modport source (output valid, status, out_kind, out_left, out_top, out_right, out_bottom,
                  out_payload, queue_count, queue_nonempty, last, input ready);
  modport sink (input valid, status, out_kind, out_left, out_top, out_right, out_bottom,
                out_payload, queue_count, queue_nonempty, last, output ready);
endinterface

// ===== rtl/core/eqpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module eqpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/eqpc_ctrl.sv =====
// Controller state machine sequencing insert, take and paint coalescing scan.
`timescale 1ns / 1ps
module eqpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  eqpc_pkg::dp_stat_t  stat,
  output eqpc_pkg::ctl_cmd_t  cmd
);
  import eqpc_pkg::*;

  state_t state, state_next;
  // Set when the delivery follows an insert that answered a held take.
  logic   chained, chained_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chained <= 1'b0;
    end else begin
      state <= state_next;
      chained <= chained_next;
    end
  end

  always_comb begin
    state_next = state;
    chained_next = chained;
    cmd = '0;
    cmd.out_status = ST_INSERTED;
    in_ready = (state == S_IDLE) && !stat.out_busy;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.cap_req = 1'b1;
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        unique case (stat.op)
          OP_APPEND, OP_PREPEND: begin
            if (stat.full) begin
              cmd.set_out = 1'b1;
              cmd.out_status = ST_FULL;
              cmd.out_last = 1'b1;
              state_next = S_IDLE;
            end else if (stat.pending) begin
              cmd.do_insert = 1'b1;
              cmd.clr_pending = 1'b1;
              chained_next = 1'b1;
              state_next = S_OUT;
            end else begin
              cmd.do_insert = 1'b1;
              cmd.set_out = 1'b1;
              cmd.out_status = ST_INSERTED;
              cmd.out_last = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_TAKE: begin
            if (!stat.empty) begin
              cmd.take_rd = 1'b1;
              chained_next = 1'b0;
              state_next = S_TAKE_RD;
            end else begin
              cmd.set_out = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_status = stat.wait_req ? ST_WAITING : ST_EMPTY;
              cmd.set_pending = stat.wait_req;
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_OUT: begin
        // The inserted entry has landed in the RAM, so the head can be read now.
        cmd.take_rd = 1'b1;
        state_next = S_TAKE_RD;
      end
      S_TAKE_RD: begin
        cmd.take_load = 1'b1;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (!stat.coalesce || stat.scan_done) begin
          if (!stat.out_busy) begin
            cmd.set_out = 1'b1;
            cmd.post_take = 1'b1;
            if (chained) begin
              // The inserted beat goes first and carries the count after the take.
              cmd.out_status = ST_INSERTED;
              state_next = S_DELIVER;
            end else begin
              cmd.out_status = ST_DELIVER;
              cmd.out_ent = 1'b1;
              cmd.out_last = 1'b1;
              state_next = S_IDLE;
            end
          end
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = S_SCAN_WR;
        end
      end
      S_SCAN_WR: begin
        cmd.scan_step = 1'b1;
        state_next = S_SCAN_RD;
      end
      S_DELIVER: begin
        if (!stat.out_busy) begin
          cmd.set_out = 1'b1;
          cmd.post_take = 1'b1;
          cmd.out_status = ST_DELIVER;
          cmd.out_ent = 1'b1;
          cmd.out_last = 1'b1;
          chained_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_scan_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |=> cmd.scan_step)
    else $error("scan read without step");
  a_take_load: assert property (@(posedge clk) disable iff (rst)
    cmd.take_rd |=> cmd.take_load)
    else $error("take read not loaded");
`endif
endmodule

// ===== rtl/core/eqpc_dp.sv =====
// Datapath: queue storage, pointers, rectangle merge and result register.
`timescale 1ns / 1ps
module eqpc_dp #(
  parameter int QueueDepth = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  eqpc_pkg::req_t      req,
  input  eqpc_pkg::ctl_cmd_t  cmd,
  output eqpc_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output eqpc_pkg::rsp_t      rsp,
  output logic [4:0]          queue_count
);
  import eqpc_pkg::*;

  localparam int AW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  logic [15:0]  paint_kind;
  req_t         rq;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          pending;
  entry_t        res;
  logic          coalesce;
  logic [CW-1:0] scan_i, scan_n, kept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] d;
    d = s - (AW + 1)'(QueueDepth);
    return (s >= (AW + 1)'(QueueDepth)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  function automatic logic is_empty(input entry_t e);
    return (e.r <= e.l) || (e.b <= e.t);
  endfunction

  function automatic entry_t merge(input entry_t d, input entry_t s);
    entry_t o;
    o = d;
    if (is_empty(d) && is_empty(s)) begin
      o.l = '0; o.t = '0; o.r = '0; o.b = '0;
    end else if (is_empty(d)) begin
      o.l = s.l; o.t = s.t; o.r = s.r; o.b = s.b;
    end else if (!is_empty(s)) begin
      if (s.l < d.l) o.l = s.l;
      if (s.t < d.t) o.t = s.t;
      if (s.r > d.r) o.r = s.r;
      if (s.b > d.b) o.b = s.b;
    end
    return o;
  endfunction

  logic [AW-1:0] head_dec;
  assign head_dec = (head == '0) ? AW'(QueueDepth - 1) : head - 1'b1;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = wrap({1'b0, head} + (AW + 1)'(count));
    ram_wdata = rq.ent;
    ram_raddr = head;
    if (cmd.do_insert) begin
      ram_we = 1'b1;
      if (rq.op == OP_PREPEND) ram_waddr = head_dec;
    end
    if (cmd.take_rd) ram_raddr = head;
    if (cmd.scan_rd) ram_raddr = wrap({1'b0, head} + (AW + 1)'(scan_i));
    if (cmd.scan_step && ram_rdata.kind != paint_kind) begin
      ram_we = 1'b1;
      ram_waddr = wrap({1'b0, head} + (AW + 1)'(kept));
      ram_wdata = ram_rdata;
    end
  end

  eqpc_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      paint_kind <= PaintKindReset;
      head <= '0;
      count <= '0;
      pending <= 1'b0;
      out_valid <= 1'b0;
      coalesce <= 1'b0;
    end else begin
      if (cfg_we) paint_kind <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.do_insert) begin
        count <= count + 1'b1;
        if (rq.op == OP_PREPEND) head <= head_dec;
      end
      if (cmd.set_pending) pending <= 1'b1;
      if (cmd.clr_pending) pending <= 1'b0;
      if (cmd.take_load) begin
        head <= wrap({1'b0, head} + 1'b1);
        count <= count - 1'b1;
        coalesce <= (ram_rdata.kind == paint_kind) && (count != CW'(1));
      end
      if (cmd.set_out) begin
        out_valid <= 1'b1;
        if (cmd.post_take && coalesce) count <= kept;
      end
    end
  end

  // Payload registers; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.cap_req) rq <= req;
    if (cmd.take_load) begin
      res <= ram_rdata;
      scan_i <= '0;
      kept <= '0;
      scan_n <= count - 1'b1;
    end
    if (cmd.scan_step) begin
      scan_i <= scan_i + 1'b1;
      if (ram_rdata.kind != paint_kind) kept <= kept + 1'b1;
    end
    if (cmd.scan_step && ram_rdata.kind == paint_kind) res <= merge(res, ram_rdata);
    if (cmd.set_out) begin
      rsp.status <= cmd.out_status;
      rsp.ent <= cmd.out_ent ? res : '0;
      rsp.last <= cmd.out_last;
      if (cmd.post_take && coalesce) begin
        queue_count <= 5'(kept);
      end else if (cmd.do_insert) begin
        queue_count <= 5'(count + 1'b1);
      end else begin
        queue_count <= 5'(count);
      end
    end
  end

  assign stat.op = rq.op;
  assign stat.wait_req = rq.wait_req;
  assign stat.full = (count == CW'(QueueDepth));
  assign stat.empty = (count == '0);
  assign stat.pending = pending;
  assign stat.coalesce = coalesce;
  assign stat.scan_done = (scan_i == scan_n);
  assign stat.out_busy = out_valid && !out_ready;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QueueDepth))
    else $error("count over depth");
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> kept <= scan_i)
    else $error("kept ahead of scan");
  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_pending |=> !pending)
    else $error("pending not cleared");
`endif
endmodule

// ===== rtl/core/event_queue_paint_coalescing_top.sv =====
// Top level of the bounded message deque with paint coalescing.
// An insert, full refusal or empty take is answered from S_INSERT. A take passes S_INSERT,
// S_TAKE_RD and S_SCAN_RD, plus S_SCAN_WR and S_SCAN_RD per other queued entry when the
// head is a paint message, as the scan reads and rewrites one entry at a time. An insert
// answering a held take also passes S_OUT and sends two beats; the next item is
// accepted once the last beat leaves. Reset (rst) empties the queue, sets paint_kind to 15.
`timescale 1ns / 1ps
module event_queue_paint_coalescing_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  eqpc_req_if.sink     req,
  eqpc_rsp_if.source   rsp
);
  import eqpc_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  req_t     rq;
  rsp_t     rs;
  logic [4:0] qc;

  assign rq.op = op_t'(req.op);
  assign rq.wait_req = req.wait_req;
  assign rq.ent = '{kind: req.msg_kind, l: req.rect_left, t: req.rect_top,
                   r: req.rect_right, b: req.rect_bottom, pay: req.payload};

  eqpc_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready), .stat, .cmd
  );

  eqpc_dp #(.QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk, .rst, .cfg_we, .cfg_wdata, .req(rq), .cmd, .stat,
    .out_valid(rsp.valid), .out_ready(rsp.ready), .rsp(rs), .queue_count(qc)
  );

  assign rsp.status = rs.status;
  assign rsp.out_kind = rs.ent.kind;
  assign rsp.out_left = rs.ent.l;
  assign rsp.out_top = rs.ent.t;
  assign rsp.out_right = rs.ent.r;
  assign rsp.out_bottom = rs.ent.b;
  assign rsp.out_payload = rs.ent.pay;
  assign rsp.queue_count = qc;
  assign rsp.queue_nonempty = (qc != '0);
  assign rsp.last = rs.last;
endmodule
